@@ hw/rtl/stepper_ramp_pulse_generator_assert.svh @@
// Assertion macros for the stepper ramp pulse generator checks.
// Expects signals named clk and rst in the scope of use.
`ifndef STEPPER_RAMP_PULSE_GENERATOR_ASSERT_SVH
`define STEPPER_RAMP_PULSE_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SRPG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srpg check failed");

// Next-cycle implication, disabled in reset.
`define SRPG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srpg check failed");

`endif

@@ hw/rtl/srpg_pkg.sv @@
// Shared types and constants for the stepper ramp pulse generator.
// No dependencies.
package srpg_pkg;

  localparam int SPEED_W = 16;
  localparam int REQ_W   = 17;
  localparam int TICKS_PER_SECOND_DEF = 1000000;

  localparam logic [SPEED_W-1:0] TARGET_SPEED_RST = 16'd1200;
  localparam logic [SPEED_W-1:0] START_SPEED_RST  = 16'd100;
  localparam logic [SPEED_W-1:0] ACCEL_INC_RST    = 16'd20;
  localparam logic [SPEED_W-1:0] DECEL_DEC_RST    = 16'd50;

  typedef enum logic [2:0] {
    MODE_STOPPED = 3'd0,
    MODE_ACCEL   = 3'd1,
    MODE_RUN     = 3'd2,
    MODE_DECEL   = 3'd3,
    MODE_DIRECT  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_RAMP  = 3'd1,
    OP_START = 3'd2,
    OP_STOP  = 3'd3,
    OP_SET   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    REG_TARGET = 2'd0,
    REG_START  = 2'd1,
    REG_ACCEL  = 2'd2,
    REG_DECEL  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_t;

endpackage

@@ hw/rtl/stepper_ramp_pulse_generator.sv @@
// Flow: accept leads straight to S_EMIT when no half period is recomputed or the new speed
// is zero; when a nonzero speed needs a new half period, S_DIV runs first and forms
// DW = clog2(TICKS_PER_SECOND+1) quotient bits, one quotient bit a cycle; S_EMIT then
// registers the result and raises out_valid once the output is free. One item at a time:
// the next item is accepted back in S_IDLE, later while a result waits on out_ready.
// Reset: synchronous, active high; defaults, driver off. Uses srpg_pkg.
module stepper_ramp_pulse_generator
  import srpg_pkg::*;
#(
  parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          op,
  input  logic [REQ_W-1:0]    requested_speed,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          mode,
  output logic [SPEED_W-1:0]  speed,
  output logic                step_out,
  output logic                driver_enable_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [SPEED_W-1:0]  cfg_data
);

  localparam int DW    = $clog2(TICKS_PER_SECOND + 1);
  localparam int HP_W  = $clog2(TICKS_PER_SECOND / 2 + 1);
  localparam int CNT_W = $clog2(DW);
  localparam int DEN_W = SPEED_W + 1;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DW - 1);
  localparam logic [DW-1:0]    TPS_VEC  = DW'(TICKS_PER_SECOND);

  state_t state, state_next;

  logic [SPEED_W-1:0] target_speed, start_speed, accel_inc, decel_dec;

  mode_t              motor_mode, motor_mode_next;
  logic [SPEED_W-1:0] cur_speed, cur_speed_next;
  logic [HP_W-1:0]    half_period, half_period_next;
  logic [HP_W-1:0]    tick_count, tick_count_next;
  logic               step_level, step_level_next;
  logic               pulse_active, pulse_active_next;
  logic               driver_disabled, driver_disabled_next;

  logic [DEN_W-1:0]   div_rem, div_den;
  logic [DW-1:0]      div_quo;
  logic [CNT_W-1:0]   div_cnt;
  logic               div_go;

  logic [DEN_W:0]     rem_sh, rem_diff;
  logic               rem_ge;
  logic [DEN_W-1:0]   rem_step;
  logic [DW-1:0]      quo_step;
  logic               div_done;
  logic               accept, emit;

  assign accept    = in_valid && in_ready;
  assign emit      = (state == S_EMIT) && (!out_valid || out_ready);
  assign div_done  = (state == S_DIV) && (div_cnt == '0);
  assign cfg_ready = !rst;

  // restoring divide step
  assign rem_sh   = {div_rem, div_quo[DW-1]};
  assign rem_diff = rem_sh - {1'b0, div_den};
  assign rem_ge   = (rem_sh >= {1'b0, div_den});
  assign rem_step = rem_ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  assign quo_step = {div_quo[DW-2:0], rem_ge};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = div_go ? S_DIV : S_EMIT;
        end
      end
      S_DIV: begin
        if (div_cnt == '0) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    unique case (state)
      S_IDLE:  in_ready = !rst;
      S_DIV:   in_ready = 1'b0;
      S_EMIT:  in_ready = 1'b0;
      default: in_ready = 1'b0;
    endcase
  end

  always_comb begin
    logic              retime;
    logic              stop_all;
    logic [SPEED_W:0]  acc_sum;
    logic [HP_W-1:0]   tick_inc;
    logic [SPEED_W-1:0] req;
    logic              upd;

    motor_mode_next      = motor_mode;
    cur_speed_next       = cur_speed;
    half_period_next     = half_period;
    tick_count_next      = tick_count;
    step_level_next      = step_level;
    pulse_active_next    = pulse_active;
    driver_disabled_next = driver_disabled;
    div_go   = 1'b0;
    retime   = 1'b0;
    stop_all = 1'b0;
    acc_sum  = {1'b0, cur_speed} + {1'b0, accel_inc};
    tick_inc = tick_count + 1'b1;
    req      = requested_speed[REQ_W-1] ? '0 : requested_speed[SPEED_W-1:0];
    upd      = (req != cur_speed) ||
               ((req != '0) && (motor_mode == MODE_STOPPED)) ||
               ((req == '0) && (motor_mode != MODE_STOPPED));

    if (accept) begin
      unique case (op_t'(op))
        OP_TICK: begin
          if (pulse_active) begin
            if (tick_inc >= half_period) begin
              tick_count_next = '0;
              step_level_next = ~step_level;
            end else begin
              tick_count_next = tick_inc;
            end
          end
        end
        OP_RAMP: begin
          unique case (motor_mode)
            MODE_ACCEL: begin
              if (cur_speed < target_speed) begin
                cur_speed_next = (acc_sum > {1'b0, target_speed}) ?
                                 target_speed : acc_sum[SPEED_W-1:0];
                retime = 1'b1;
              end else begin
                motor_mode_next = MODE_RUN;
                if (cur_speed != target_speed) begin
                  cur_speed_next = target_speed;
                  retime = 1'b1;
                end
              end
            end
            MODE_DECEL: begin
              if (cur_speed != '0 && decel_dec < cur_speed) begin
                cur_speed_next = cur_speed - decel_dec;
                retime = 1'b1;
              end else begin
                stop_all = 1'b1;
              end
            end
            MODE_STOPPED: begin
              if (!driver_disabled || pulse_active) begin
                driver_disabled_next = 1'b1;
                pulse_active_next    = 1'b0;
                tick_count_next      = '0;
                step_level_next      = 1'b0;
              end
            end
            default: ;
          endcase
        end
        OP_START: begin
          if (motor_mode == MODE_STOPPED) begin
            motor_mode_next      = MODE_ACCEL;
            cur_speed_next       = start_speed;
            driver_disabled_next = 1'b0;
            retime = 1'b1;
          end
        end
        OP_STOP: begin
          if (motor_mode == MODE_RUN || motor_mode == MODE_ACCEL) begin
            motor_mode_next = MODE_DECEL;
          end else if (motor_mode == MODE_DIRECT) begin
            stop_all = 1'b1;
          end
        end
        OP_SET: begin
          if (upd) begin
            cur_speed_next = req;
            if (req != '0) begin
              if (motor_mode == MODE_STOPPED) begin
                driver_disabled_next = 1'b0;
              end
              motor_mode_next = MODE_DIRECT;
              retime = 1'b1;
            end else if (motor_mode != MODE_STOPPED) begin
              stop_all = 1'b1;
            end
          end
        end
        default: ;
      endcase

      if (stop_all) begin
        motor_mode_next      = MODE_STOPPED;
        cur_speed_next       = '0;
        pulse_active_next    = 1'b0;
        tick_count_next      = '0;
        step_level_next      = 1'b0;
        driver_disabled_next = 1'b1;
      end

      if (retime) begin
        tick_count_next = '0;
        if (cur_speed_next == '0) begin
          half_period_next  = '0;
          pulse_active_next = 1'b0;
          step_level_next   = 1'b0;
        end else begin
          div_go = 1'b1;
        end
      end
    end

    if (div_done) begin
      half_period_next = quo_step[HP_W-1:0];
      if (quo_step == '0) begin
        pulse_active_next = 1'b0;
        step_level_next   = 1'b0;
      end else begin
        pulse_active_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      target_speed    <= TARGET_SPEED_RST;
      start_speed     <= START_SPEED_RST;
      accel_inc       <= ACCEL_INC_RST;
      decel_dec       <= DECEL_DEC_RST;
      motor_mode      <= MODE_STOPPED;
      cur_speed       <= '0;
      half_period     <= '0;
      tick_count      <= '0;
      step_level      <= 1'b0;
      pulse_active    <= 1'b0;
      driver_disabled <= 1'b1;
      out_valid       <= 1'b0;
    end else begin
      state           <= state_next;
      motor_mode      <= motor_mode_next;
      cur_speed       <= cur_speed_next;
      half_period     <= half_period_next;
      tick_count      <= tick_count_next;
      step_level      <= step_level_next;
      pulse_active    <= pulse_active_next;
      driver_disabled <= driver_disabled_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_TARGET: target_speed <= cfg_data;
          REG_START:  start_speed  <= cfg_data;
          REG_ACCEL:  accel_inc    <= cfg_data;
          REG_DECEL:  decel_dec    <= cfg_data;
          default: ;
        endcase
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_go) begin
      div_rem <= '0;
      div_quo <= TPS_VEC;
      div_den <= {cur_speed_next, 1'b0};
      div_cnt <= DIV_LAST;
    end else if (state == S_DIV) begin
      div_rem <= rem_step;
      div_quo <= quo_step;
      div_cnt <= div_cnt - 1'b1;
    end
    if (emit) begin
      mode            <= motor_mode;
      speed           <= cur_speed;
      step_out        <= step_level;
      driver_enable_n <= driver_disabled;
    end
  end

endmodule

@@ hw/rtl/srpg_checker.sv @@
// Port-level checks for the stepper ramp pulse generator, bound to its top level.
// Uses srpg_pkg and stepper_ramp_pulse_generator_assert.svh.
`include "stepper_ramp_pulse_generator_assert.svh"

module srpg_checker
  import srpg_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [2:0]          mode,
  input logic [SPEED_W-1:0]  speed,
  input logic                step_out,
  input logic                driver_enable_n
);

  `SRPG_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(mode) && $stable(speed) && $stable(step_out) && $stable(driver_enable_n))

  `SRPG_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  `SRPG_ASSERT_IMP(a_stopped_quiet, out_valid && mode == MODE_STOPPED, step_out == 1'b0 && driver_enable_n == 1'b1 && speed == '0)

  `SRPG_ASSERT_IMP(a_moving_enabled, out_valid && mode != MODE_STOPPED, driver_enable_n == 1'b0)

endmodule

bind stepper_ramp_pulse_generator srpg_checker u_srpg_checker (.*);
